@@ rtl/cce_pkg.sv @@
// Shared types and constants for the controller change emitter.
// No dependencies; used by every module under rtl/.
package cce_pkg;

    // Default slot count
    localparam int SLOTS_DEFAULT = 32;

    // Field widths
    localparam int BYTE_W  = 8;
    localparam int CMD_W   = 2;
    localparam int LANES   = 4;
    localparam int S_DATA_W = 16;
    localparam int M_DATA_W = 24;

    // Byte lanes of one slot word
    localparam int LANE_CUR  = 0;
    localparam int LANE_SENT = 1;
    localparam int LANE_CTRL = 2;
    localparam int LANE_CHAN = 3;

    // Command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_SET_VALUE   = 2'd0,
        CMD_SET_CTRL    = 2'd1,
        CMD_SET_CHANNEL = 2'd2,
        CMD_TICK        = 2'd3
    } t_cmd;

    // One slot as stored in memory, current value in the lowest byte
    typedef struct packed {
        logic [BYTE_W-1:0] chan;
        logic [BYTE_W-1:0] ctrl;
        logic [BYTE_W-1:0] sent;
        logic [BYTE_W-1:0] cur;
    } t_slot;

    // One control-change message
    typedef struct packed {
        logic [BYTE_W-1:0] value;
        logic [BYTE_W-1:0] ctrl;
        logic [BYTE_W-1:0] chan;
    } t_msg;

    // Scanner to output stage
    typedef struct packed {
        logic push;
        logic finish;
        t_msg msg;
    } t_emit;

endpackage

@@ rtl/cce_slot_ram.sv @@
// Slot table: one synchronous memory, byte-lane writes, registered read.
// Per-lane valid flags make never-written bytes read as zero. Depends on cce_pkg.
module cce_slot_ram
    import cce_pkg::*;
#(
    parameter int NUM_SLOTS = SLOTS_DEFAULT,
    parameter int AW        = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [LANES-1:0] i_wbe,
    input  t_slot            i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output t_slot            o_rdata
);

    logic [LANES-1:0][BYTE_W-1:0] r_mem [NUM_SLOTS];
    logic [LANES-1:0]             r_vld [NUM_SLOTS];
    logic [LANES-1:0][BYTE_W-1:0] r_rdata;
    logic [LANES-1:0]             r_rvld;
    logic [LANES-1:0][BYTE_W-1:0] w_mask;

    // Memory write, byte lanes
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            for (int l = 0; l < LANES; l++) begin
                if (i_wbe[l]) begin
                    r_mem[i_waddr][l] <= i_wdata[l*BYTE_W +: BYTE_W];
                end
            end
        end
    end

    // Lane valid flags, cleared at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NUM_SLOTS; s++) begin
                r_vld[s] <= '0;
            end
        end else if (i_we) begin
            r_vld[i_waddr] <= r_vld[i_waddr] | i_wbe;
        end
    end

    // Registered read; data holds while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
            r_rvld  <= r_vld[i_raddr];
        end
    end

    // Unwritten lanes read as zero
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            w_mask[l] = r_rvld[l] ? r_rdata[l] : '0;
        end
    end

    assign o_rdata = t_slot'(w_mask);

endmodule

@@ rtl/cce_scan_seq.sv @@
// Command sequencer: applies set commands and scans the slot table on a tick.
// Depends on cce_pkg; drives cce_slot_ram and feeds cce_out_stage.
module cce_scan_seq
    import cce_pkg::*;
#(
    parameter int NUM_SLOTS = SLOTS_DEFAULT,
    parameter int AW        = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // command stream
    input  logic              i_valid,
    output logic              o_ready,
    input  t_cmd              i_cmd,
    input  logic [BYTE_W-1:0] i_index,
    input  logic [BYTE_W-1:0] i_data,
    // slot memory
    output logic              o_we,
    output logic [AW-1:0]     o_waddr,
    output logic [LANES-1:0]  o_wbe,
    output t_slot             o_wdata,
    output logic              o_re,
    output logic [AW-1:0]     o_raddr,
    input  t_slot             i_rdata,
    // output stage
    input  logic              i_can_push,
    output t_emit             o_emit
);

    localparam int CW = $clog2(NUM_SLOTS + 1);

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } t_state;

    t_state        r_state, n_state;
    logic          r_has_ticked, n_has_ticked;
    logic [CW-1:0] r_rd_cnt, n_rd_cnt;
    logic          r_dv, n_dv;
    logic [AW-1:0] r_dv_addr, n_dv_addr;

    logic w_change, w_adv, w_more, w_in_range;

    assign w_change   = r_dv && r_has_ticked && (i_rdata.sent != i_rdata.cur);
    assign w_adv      = !w_change || i_can_push;
    assign w_more     = r_rd_cnt != CW'(NUM_SLOTS);
    assign w_in_range = {1'b0, i_index} < 9'(NUM_SLOTS);
    assign o_ready    = r_state == ST_IDLE;

    // Next state, memory access and emission
    always_comb begin
        n_state      = r_state;
        n_has_ticked = r_has_ticked;
        n_rd_cnt     = r_rd_cnt;
        n_dv         = r_dv;
        n_dv_addr    = r_dv_addr;
        o_we         = 1'b0;
        o_waddr      = r_dv_addr;
        o_wbe        = '0;
        o_wdata      = '0;
        o_re         = 1'b0;
        o_raddr      = r_rd_cnt[AW-1:0];
        o_emit.push  = 1'b0;
        o_emit.finish = 1'b0;
        o_emit.msg.chan  = i_rdata.chan;
        o_emit.msg.ctrl  = i_rdata.ctrl;
        o_emit.msg.value = i_rdata.cur;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    if (i_cmd == CMD_TICK) begin
                        n_state  = ST_SCAN;
                        n_rd_cnt = '0;
                        n_dv     = 1'b0;
                    end else if (w_in_range) begin
                        o_we    = 1'b1;
                        o_waddr = i_index[AW-1:0];
                        o_wdata = {LANES{i_data}};
                        unique case (i_cmd)
                            CMD_SET_VALUE: o_wbe[LANE_CUR]  = 1'b1;
                            CMD_SET_CTRL:  o_wbe[LANE_CTRL] = 1'b1;
                            default:       o_wbe[LANE_CHAN] = 1'b1;
                        endcase
                    end
                end
            end
            ST_SCAN: begin
                if (!r_dv && !w_more) begin
                    // scan drained: flag the last message once it can move
                    if (i_can_push) begin
                        o_emit.finish = 1'b1;
                        n_has_ticked  = 1'b1;
                        n_state       = ST_IDLE;
                    end
                end else if (w_adv) begin
                    // write back sent value of the slot whose read data is presented
                    if (r_dv) begin
                        o_we             = 1'b1;
                        o_wbe[LANE_SENT] = 1'b1;
                        o_wdata.sent     = i_rdata.cur;
                        o_emit.push      = w_change;
                    end
                    // read the next slot
                    o_re      = w_more;
                    n_dv      = w_more;
                    n_dv_addr = r_rd_cnt[AW-1:0];
                    if (w_more) begin
                        n_rd_cnt = r_rd_cnt + CW'(1);
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // State and scan registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_has_ticked <= 1'b0;
            r_rd_cnt     <= '0;
            r_dv         <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_has_ticked <= n_has_ticked;
            r_rd_cnt     <= n_rd_cnt;
            r_dv         <= n_dv;
        end
        r_dv_addr <= n_dv_addr;
    end

endmodule

@@ rtl/cce_out_stage.sv @@
// Output stage: one message held back so the final one of a run gets tlast,
// plus the output register toward the master side. Depends on cce_pkg.
module cce_out_stage
    import cce_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_emit i_emit,
    output logic  o_can_push,
    output logic  o_valid,
    input  logic  i_ready,
    output t_msg  o_msg,
    output logic  o_last
);

    logic r_pend_v;
    t_msg r_pend;
    logic r_out_v;
    t_msg r_out;
    logic r_out_last;
    logic w_out_free;

    assign w_out_free = !r_out_v || i_ready;
    assign o_can_push = !r_pend_v || w_out_free;

    // Control flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            // held message moves out on a new push or at scan end
            if ((i_emit.push || i_emit.finish) && r_pend_v) begin
                r_out_v <= 1'b1;
            end else if (i_ready) begin
                r_out_v <= 1'b0;
            end
            if (i_emit.push) begin
                r_pend_v <= 1'b1;
            end else if (i_emit.finish) begin
                r_pend_v <= 1'b0;
            end
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (i_emit.push) begin
            r_pend <= i_emit.msg;
            if (r_pend_v) begin
                r_out      <= r_pend;
                r_out_last <= 1'b0;
            end
        end else if (i_emit.finish && r_pend_v) begin
            r_out      <= r_pend;
            r_out_last <= 1'b1;
        end
    end

    assign o_valid = r_out_v;
    assign o_msg   = r_out;
    assign o_last  = r_out_last;

endmodule

@@ rtl/controller_change_emitter.sv @@
// Controller change emitter, top level. Set transfers go back to back while idle.
// A tick holds off the input until its scan ends; the scan reads one slot per
// cycle, unless the output stalls, through the single read port of the slot memory.
// A result leaves one changed slot later than it is found (the last one at scan end).
// Synchronous active-low reset clears all slot fields to zero at once through
// per-lane valid flags; no clearing pass follows. Depends on cce_pkg and submodules.
module controller_change_emitter
    import cce_pkg::*;
#(
    parameter int NUM_SLOTS = SLOTS_DEFAULT
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    // command: [7:0] index, [15:8] data
    input  logic [S_DATA_W-1:0] i_s_tdata,
    // [1:0] command
    input  logic [CMD_W-1:0]    i_s_tuser,
    // message: [7:0] msg_channel, [15:8] msg_controller, [23:16] msg_value
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    output logic [M_DATA_W-1:0] o_m_tdata,
    output logic                o_m_tlast
);

    localparam int AW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    logic             w_we, w_re, w_can_push;
    logic [AW-1:0]    w_waddr, w_raddr;
    logic [LANES-1:0] w_wbe;
    t_slot            w_wdata, w_rdata;
    t_emit            w_emit;
    t_msg             w_msg;

    cce_slot_ram #(
        .NUM_SLOTS (NUM_SLOTS),
        .AW        (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wbe   (w_wbe),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    cce_scan_seq #(
        .NUM_SLOTS (NUM_SLOTS),
        .AW        (AW)
    ) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_s_tvalid),
        .o_ready    (o_s_tready),
        .i_cmd      (t_cmd'(i_s_tuser)),
        .i_index    (i_s_tdata[BYTE_W-1:0]),
        .i_data     (i_s_tdata[BYTE_W +: BYTE_W]),
        .o_we       (w_we),
        .o_waddr    (w_waddr),
        .o_wbe      (w_wbe),
        .o_wdata    (w_wdata),
        .o_re       (w_re),
        .o_raddr    (w_raddr),
        .i_rdata    (w_rdata),
        .i_can_push (w_can_push),
        .o_emit     (w_emit)
    );

    cce_out_stage u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_emit     (w_emit),
        .o_can_push (w_can_push),
        .o_valid    (o_m_tvalid),
        .i_ready    (i_m_tready),
        .o_msg      (w_msg),
        .o_last     (o_m_tlast)
    );

    assign o_m_tdata = M_DATA_W'(w_msg);

endmodule
